### hdl/mstd_pkg.sv
// Types, codes and reset values shared by the magnetic stripe track decoder.
package mstd_pkg;

	// One stripe bit request.
	typedef struct packed {
		logic card_bit;
		logic swipe_end;
	} bit_item_t;

	// One result request.
	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] char_value;
		logic       last;
	} res_item_t;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_DECODE = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SYM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_SYM    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_SYM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ASCII_OFS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS  = 3'd7;

	localparam logic [3:0] RST_CHAR_BITS = 4'd5;
	localparam logic [6:0] RST_START_SYM = 7'd11;
	localparam logic [6:0] RST_SEP_SYM   = 7'd13;
	localparam logic [6:0] RST_END_SYM   = 7'd15;
	localparam logic [6:0] RST_MIN_VALUE = 7'd0;
	localparam logic [6:0] RST_MAX_VALUE = 7'd9;
	localparam logic [6:0] RST_ASCII_OFS = 7'd48;
	localparam logic [7:0] RST_MAX_CHARS = 8'd40;

	// Data bits per character: char_bits clamped to 3..8, minus the parity bit.
	function automatic logic [2:0] data_bits(input logic [3:0] cb);
		logic [2:0] d;
		if (cb < 4'd3) begin
			d = 3'd2;
		end else if (cb > 4'd8) begin
			d = 3'd7;
		end else begin
			d = 3'(cb - 4'd1);
		end
		return d;
	endfunction

endpackage

### hdl/magstripe_track_decoder_core.sv
// Magnetic stripe track decoder: sentinel hunt, character decode, parity and LRC check.
//
//  channel | signals                         | moves
//  --------+---------------------------------+-----------------------------------
//  bit     | bit_valid, bit_ready, bit_data  | one stripe bit request, LSB first
//  res     | res_valid, res_ready, res_data  | one result request (char/ok/error)
//  cfg     | cfg_wen, cfg_idx, cfg_data      | register write, no wait
//
// One bit request is taken per cycle; its state update and results land in the same
// cycle in the state registers and a 4-entry result queue. The queue drains one result
// per cycle on res_ready; bit_ready drops above two queued results, as one bit can
// add two. arst_n clears the decode state, the queue and loads register defaults.
module magstripe_track_decoder_core
	import mstd_pkg::*;
#(
	parameter int          HUNT_BITS   = 256,
	parameter logic        PARITY_INIT = 1'b1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bit_valid,
	output logic                   bit_ready,
	input  bit_item_t              bit_data,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_item_t              res_data,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int HCW = $clog2(HUNT_BITS + 1);
	localparam logic [HCW-1:0] HUNT_LIMIT = HCW'(HUNT_BITS);
	localparam int QD = 4;

	// configuration
	logic [3:0] char_bits_q;
	logic [6:0] start_sym_q, sep_sym_q, end_sym_q, min_value_q, max_value_q, ascii_ofs_q;
	logic [7:0] max_chars_q;

	// decode state
	phase_t         phase_q, phase_n;
	logic [6:0]     win_q, win_n;
	logic [2:0]     pos_q, pos_n;
	logic           par_q, par_n;
	logic [6:0]     lrc_q, lrc_n;
	logic [1:0]     sent_q, sent_n;
	logic [7:0]     pay_cnt_q, pay_cnt_n;
	logic [HCW-1:0] hunt_cnt_q, hunt_cnt_n;

	// result queue, head at entry 0
	res_item_t  rq_q [QD];
	res_item_t  rq_n [QD];
	res_item_t  rq_sh [QD];
	logic [2:0] rq_cnt_q, rq_cnt_n;

	logic       take, pop;
	logic       r0_vld, r1_vld;
	res_item_t  r0, r1;

	assign take      = bit_valid && bit_ready;
	assign res_valid = (rq_cnt_q != 3'd0);
	assign res_data  = rq_q[0];
	assign pop       = res_valid && res_ready;
	assign bit_ready = (rq_cnt_q <= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bits_q <= RST_CHAR_BITS;
			start_sym_q <= RST_START_SYM;
			sep_sym_q   <= RST_SEP_SYM;
			end_sym_q   <= RST_END_SYM;
			min_value_q <= RST_MIN_VALUE;
			max_value_q <= RST_MAX_VALUE;
			ascii_ofs_q <= RST_ASCII_OFS;
			max_chars_q <= RST_MAX_CHARS;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_CHAR_BITS: char_bits_q <= cfg_data[3:0];
				CFG_START_SYM: start_sym_q <= cfg_data[6:0];
				CFG_SEP_SYM:   sep_sym_q   <= cfg_data[6:0];
				CFG_END_SYM:   end_sym_q   <= cfg_data[6:0];
				CFG_MIN_VALUE: min_value_q <= cfg_data[6:0];
				CFG_MAX_VALUE: max_value_q <= cfg_data[6:0];
				CFG_ASCII_OFS: ascii_ofs_q <= cfg_data[6:0];
				CFG_MAX_CHARS: max_chars_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-bit decode step.
	always_comb begin
		logic [2:0] d;
		logic [6:0] mask;
		logic [6:0] hwin;
		logic [6:0] val;
		logic [7:0] limit;
		logic       is_s0, is_s1, is_s2, is_fin, is_pay;
		logic       step_vld;
		res_item_t  step_res;

		d        = data_bits(char_bits_q);
		mask     = 7'((8'd1 << d) - 8'd1);
		hwin     = ((win_q >> 1) | (7'(bit_data.card_bit) << (d - 3'd1))) & mask;
		val      = win_q & mask;
		limit    = (max_chars_q == 8'd0) ? 8'd0 : max_chars_q - 8'd1;
		is_s0    = (sent_q == 2'd0) && (val == start_sym_q);
		is_s1    = (sent_q == 2'd1) && (val == sep_sym_q);
		is_s2    = (sent_q == 2'd2) && (val == end_sym_q);
		is_fin   = (sent_q == 2'd3) && (val == lrc_q);
		is_pay   = !(is_s0 || is_s1 || is_s2 || is_fin) &&
			(val >= min_value_q) && (val <= max_value_q);

		phase_n    = phase_q;
		win_n      = win_q;
		pos_n      = pos_q;
		par_n      = par_q;
		lrc_n      = lrc_q;
		sent_n     = sent_q;
		pay_cnt_n  = pay_cnt_q;
		hunt_cnt_n = hunt_cnt_q;
		step_vld   = 1'b0;
		step_res   = '{result_kind: KIND_ERR, char_value: 8'd0, last: 1'b0};

		unique case (phase_q)
			PH_HUNT: begin
				win_n = hwin;
				if (hunt_cnt_q < HUNT_LIMIT) begin
					hunt_cnt_n = hunt_cnt_q + HCW'(1);
				end
				if ((hunt_cnt_n >= HCW'(d)) && (hwin == start_sym_q)) begin
					phase_n   = PH_DECODE;
					pos_n     = d;
					par_n     = PARITY_INIT ^ (^hwin);
					lrc_n     = PARITY_INIT ? mask : 7'd0;
					sent_n    = 2'd0;
					pay_cnt_n = 8'd0;
				end else if (hunt_cnt_n >= HUNT_LIMIT) begin
					step_vld = 1'b1;
					phase_n  = PH_DONE;
				end
			end
			PH_DECODE: begin
				if (pos_q < d) begin
					win_n = win_q | (7'(bit_data.card_bit) << pos_q);
					par_n = par_q ^ bit_data.card_bit;
					pos_n = pos_q + 3'd1;
				end else begin
					win_n = 7'd0;
					pos_n = 3'd0;
					par_n = PARITY_INIT;
					if ((par_q != bit_data.card_bit) ||
						!(is_s0 || is_s1 || is_s2 || is_fin || is_pay)) begin
						step_vld = 1'b1;
						phase_n  = PH_DONE;
					end else begin
						lrc_n = lrc_q ^ val;
						if (is_s0) sent_n = 2'd1;
						if (is_s1) sent_n = 2'd2;
						if (is_s2) sent_n = 2'd3;
						// capacity counts payload characters only, checked on every valid character
						if (pay_cnt_q >= limit) begin
							step_vld = 1'b1;
							phase_n  = PH_DONE;
						end else if (is_pay) begin
							step_vld = 1'b1;
							step_res.result_kind = KIND_CHAR;
							step_res.char_value  = 8'(val) + 8'(ascii_ofs_q);
							pay_cnt_n = pay_cnt_q + 8'd1;
						end else if (is_fin) begin
							step_vld = 1'b1;
							step_res.result_kind = KIND_OK;
							phase_n = PH_DONE;
						end
					end
				end
			end
			default: ;
		endcase

		r0     = step_res;
		r0_vld = step_vld;
		r1     = '{result_kind: KIND_ERR, char_value: 8'd0, last: 1'b1};
		r1_vld = 1'b0;

		if (bit_data.swipe_end) begin
			if (phase_n == PH_HUNT || phase_n == PH_DECODE) begin
				if (step_vld) begin
					r1_vld = 1'b1;
				end else begin
					r0_vld = 1'b1;
					r0     = r1;
				end
			end
			phase_n    = PH_HUNT;
			win_n      = 7'd0;
			pos_n      = 3'd0;
			par_n      = PARITY_INIT;
			lrc_n      = PARITY_INIT ? mask : 7'd0;
			sent_n     = 2'd0;
			pay_cnt_n  = 8'd0;
			hunt_cnt_n = '0;
		end
		r0.last = !r1_vld;
	end

	// Queue update: shift on pop, append new results behind what remains.
	always_comb begin
		logic [2:0] base;
		base = rq_cnt_q - 3'(pop);
		for (int i = 0; i < QD - 1; i++) begin
			rq_sh[i] = pop ? rq_q[i+1] : rq_q[i];
		end
		rq_sh[QD-1] = rq_q[QD-1];
		for (int i = 0; i < QD; i++) begin
			if (take && r0_vld && (base == 3'(i))) begin
				rq_n[i] = r0;
			end else if (take && r1_vld && ((base + 3'd1) == 3'(i))) begin
				rq_n[i] = r1;
			end else begin
				rq_n[i] = rq_sh[i];
			end
		end
		rq_cnt_n = base + (take ? (3'(r0_vld) + 3'(r1_vld)) : 3'd0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QD; i++) begin
			rq_q[i] <= rq_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			win_q      <= 7'd0;
			pos_q      <= 3'd0;
			par_q      <= PARITY_INIT;
			lrc_q      <= PARITY_INIT ? 7'h0f : 7'd0;
			sent_q     <= 2'd0;
			pay_cnt_q  <= 8'd0;
			hunt_cnt_q <= '0;
			rq_cnt_q   <= 3'd0;
		end else begin
			if (take) begin
				phase_q    <= phase_n;
				win_q      <= win_n;
				pos_q      <= pos_n;
				par_q      <= par_n;
				lrc_q      <= lrc_n;
				sent_q     <= sent_n;
				pay_cnt_q  <= pay_cnt_n;
				hunt_cnt_q <= hunt_cnt_n;
			end
			rq_cnt_q <= rq_cnt_n;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_swipe_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && bit_data.swipe_end |=> phase_q == PH_HUNT && hunt_cnt_q == '0)
		else $error("no rearm after swipe end");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> sent_q == 2'd0 && pay_cnt_q == 8'd0)
		else $error("hunting with stale track state");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !take |=> rq_cnt_q == $past(rq_cnt_q) - 3'd1)
		else $error("queue count lost a drained result");

endmodule
